/* hdl/mtjl_pkg.sv */
// ----------------------------------------------------------------------------
// mtjl_pkg
// Shared types and constants for the membership table join/leave core.
// ----------------------------------------------------------------------------
package mtjl_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int ID_BYTES_DEF    = 8;

    localparam int NODE_ID_W = 64;
    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 16;
    localparam int VER_W     = 32;
    localparam int ERR_W     = 3;
    localparam int SLOT_W    = 5;

    localparam logic OP_JOIN  = 1'b0;
    localparam logic OP_LEAVE = 1'b1;

    localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_MALFORMED   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_FULL        = 3'd2;
    localparam logic [ERR_W-1:0] ERR_UNSUPPORTED = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_KIND    = 3'd4;

    typedef struct packed {
        logic                 operation;
        logic                 header_is_join;
        logic [NODE_ID_W-1:0] source_id;
        logic [NODE_ID_W-1:0] member_id;
        logic [1:0]           member_kind;
        logic [ADDR_W-1:0]    member_address;
        logic [PORT_W-1:0]    member_port;
    } req_t;

    typedef struct packed {
        logic                 accepted;
        logic [ERR_W-1:0]     error_code;
        logic [NODE_ID_W-1:0] ack_id;
        logic [VER_W-1:0]     assigned_version;
        logic [SLOT_W-1:0]    entry_slot;
    } rsp_t;

endpackage

/* hdl/membership_table_join_leave_core.sv */
// flow: a rejected join, or any request on an empty table, goes from idle straight to the write step;
//   otherwise k entries are scanned first, where k <= TABLE_DEPTH, stopping at the first key hit
// one request at a time, one table entry read per cycle while scanning; the write step waits on
//   m_ready stalls, and the next transfer can be taken while that result still waits on m_ready
// reset: synchronous, active low; clears the entry count and the control state,
//   table contents are left as they are since slots at or above the count are never read
// ----------------------------------------------------------------------------
// membership_table_join_leave_core
// Member table keyed by address and port for a join and by node id for a leave.
// ----------------------------------------------------------------------------
module membership_table_join_leave_core #(
    parameter int TABLE_DEPTH = mtjl_pkg::TABLE_DEPTH_DEF,
    parameter int ID_BYTES    = mtjl_pkg::ID_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mtjl_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mtjl_pkg::rsp_t m_data
);

    localparam int ID_W   = 8 * ID_BYTES;
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = mtjl_pkg::ADDR_W;
    localparam int PORT_W = mtjl_pkg::PORT_W;
    localparam int VER_W  = mtjl_pkg::VER_W;
    localparam int SLOT_W = mtjl_pkg::SLOT_W;
    localparam int ERR_W  = mtjl_pkg::ERR_W;
    // entry word: node id, address, port, superpeer flag, removed flag, version
    localparam int ENT_W  = ID_W + ADDR_W + PORT_W + 2 + VER_W;
    localparam int RMV_B  = VER_W;
    localparam int PORT_L = VER_W + 2;
    localparam int ADDR_L = PORT_L + PORT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    state_t            state_reg, state_next;
    logic              op_reg, op_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic              super_reg, super_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [ENT_W-1:0]  hit_ent_reg, hit_ent_next;
    logic              m_valid_reg, m_valid_next;
    mtjl_pkg::rsp_t    m_data_reg, m_data_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [ENT_W-1:0]  rd_data;

    logic [ID_W-1:0]   in_id;
    logic [ID_W-1:0]   in_src;
    logic [ERR_W-1:0]  chk_err;
    logic [ID_W-1:0]   rd_id;
    logic [ADDR_W-1:0] rd_addr_f;
    logic [PORT_W-1:0] rd_port;
    logic              key_hit;
    logic              last_cmp;
    logic [VER_W-1:0]  hit_ver_inc;
    logic [IDX_W+SLOT_W-1:0] hit_slot_ext;
    logic [IDX_W+SLOT_W-1:0] cnt_slot_ext;

    mtjl_ram #(
        .DEPTH  (TABLE_DEPTH),
        .DATA_W (ENT_W),
        .IDX_W  (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_id  = s_data.member_id[ID_W-1:0];
    assign in_src = s_data.source_id[ID_W-1:0];

    // join checks in priority order
    always_comb begin
        if (!s_data.header_is_join) begin
            chk_err = mtjl_pkg::ERR_UNSUPPORTED;
        end else if (in_id != in_src || in_id == '0) begin
            chk_err = mtjl_pkg::ERR_MALFORMED;
        end else if (s_data.member_kind[1]) begin
            chk_err = mtjl_pkg::ERR_BAD_KIND;
        end else if (s_data.member_port == '0 || s_data.member_address == '0) begin
            chk_err = mtjl_pkg::ERR_MALFORMED;
        end else begin
            chk_err = mtjl_pkg::ERR_NONE;
        end
    end

    assign rd_id     = rd_data[ENT_W-1 -: ID_W];
    assign rd_addr_f = rd_data[ADDR_L +: ADDR_W];
    assign rd_port   = rd_data[PORT_L +: PORT_W];

    // shared key compare: node id for a leave, address and port for a join
    assign key_hit  = (op_reg == mtjl_pkg::OP_LEAVE) ? (rd_id == id_reg)
                    : (rd_addr_f == addr_reg && rd_port == port_reg);
    assign last_cmp = (CNT_W'(cmp_idx_reg) + CNT_W'(1)) == count_reg;

    assign hit_ver_inc  = hit_ent_reg[VER_W-1:0] + VER_W'(1);
    assign hit_slot_ext = {{SLOT_W{1'b0}}, hit_idx_reg};
    assign cnt_slot_ext = {{SLOT_W{1'b0}}, count_reg[IDX_W-1:0]};

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        addr_next    = addr_reg;
        port_next    = port_reg;
        super_next   = super_reg;
        err_next     = err_reg;
        count_next   = count_reg;
        iss_next     = iss_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        found_next   = found_reg;
        hit_idx_next = hit_idx_reg;
        hit_ent_next = hit_ent_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = hit_idx_reg;
        wr_data      = {id_reg, addr_reg, port_reg, super_reg, 1'b0, hit_ver_inc};
        rd_en        = 1'b0;
        rd_addr      = iss_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_data.operation;
                    id_next    = in_id;
                    addr_next  = s_data.member_address;
                    port_next  = s_data.member_port;
                    super_next = s_data.member_kind[0];
                    found_next = 1'b0;
                    iss_next   = '0;
                    err_next   = (s_data.operation == mtjl_pkg::OP_JOIN) ? chk_err
                               : mtjl_pkg::ERR_NONE;
                    if ((s_data.operation == mtjl_pkg::OP_JOIN
                            && chk_err != mtjl_pkg::ERR_NONE) || count_reg == '0) begin
                        state_next = ST_WRITE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // issue the next read while comparing the entry read last cycle
                if (iss_reg < count_reg) begin
                    rd_en        = 1'b1;
                    iss_next     = iss_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = iss_reg[IDX_W-1:0];
                end
                if (cmp_vld_reg) begin
                    if (key_hit) begin
                        found_next   = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                        hit_ent_next = rd_data;
                        state_next   = ST_WRITE;
                        rd_en        = 1'b0;
                        cmp_vld_next = 1'b0;
                    end else if (last_cmp) begin
                        state_next   = ST_WRITE;
                        rd_en        = 1'b0;
                        cmp_vld_next = 1'b0;
                    end
                end
            end
            ST_WRITE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    if (op_reg == mtjl_pkg::OP_LEAVE) begin
                        m_data_next.accepted = 1'b1;
                        m_data_next.ack_id   = mtjl_pkg::NODE_ID_W'(id_reg);
                        if (found_reg) begin
                            wr_en   = 1'b1;
                            wr_data = hit_ent_reg;
                            wr_data[RMV_B] = 1'b1;
                            m_data_next.entry_slot = hit_slot_ext[SLOT_W-1:0];
                        end
                    end else if (err_reg != mtjl_pkg::ERR_NONE) begin
                        m_data_next.error_code = err_reg;
                    end else if (found_reg) begin
                        // overwrite the matching entry, alive again, version bumped
                        wr_en = 1'b1;
                        m_data_next.accepted         = 1'b1;
                        m_data_next.ack_id           = mtjl_pkg::NODE_ID_W'(id_reg);
                        m_data_next.assigned_version = hit_ver_inc;
                        m_data_next.entry_slot       = hit_slot_ext[SLOT_W-1:0];
                    end else if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                        m_data_next.error_code = mtjl_pkg::ERR_FULL;
                    end else begin
                        // append a new entry at version zero
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        wr_data    = {id_reg, addr_reg, port_reg, super_reg, 1'b0,
                                      {VER_W{1'b0}}};
                        count_next = count_reg + CNT_W'(1);
                        m_data_next.accepted   = 1'b1;
                        m_data_next.ack_id     = mtjl_pkg::NODE_ID_W'(id_reg);
                        m_data_next.entry_slot = cnt_slot_ext[SLOT_W-1:0];
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            iss_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
            iss_reg     <= iss_next;
        end
        op_reg      <= op_next;
        id_reg      <= id_next;
        addr_reg    <= addr_next;
        port_reg    <= port_next;
        super_reg   <= super_next;
        err_reg     <= err_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_ent_reg <= hit_ent_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && count_reg != $past(count_reg))
            |-> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("entry count moved by more than one");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new transfer taken while a request is in flight");

    a_result_from_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid) && $past(aresetn)) |-> $past(state_reg == ST_WRITE))
        else $error("result raised outside the write step");

    a_reject_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.accepted)
            |-> (m_data.ack_id == '0 && m_data.error_code != mtjl_pkg::ERR_NONE))
        else $error("rejected join carries an id or no error");

endmodule

/* hdl/mtjl_ram.sv */
// ----------------------------------------------------------------------------
// mtjl_ram
// Simple dual-port table memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module mtjl_ram #(
    parameter int DEPTH  = mtjl_pkg::TABLE_DEPTH_DEF,
    parameter int DATA_W = 8,
    parameter int IDX_W  = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* dv/membership_table_join_leave_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// membership_table_join_leave_core_test
// Self-checking bench for the member table core. A directed run covers the
// join checks in their priority order, appends, overwrites, leaves and
// revives. Random joins and leaves then draw from a small pool of endpoints
// and node ids, so the table fills, overwrites and reports full. Each reply
// is compared field by field with a software copy of the table, under
// sender and receiver idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
module membership_table_join_leave_core_test;

    localparam int          DEPTH     = mtjl_pkg::TABLE_DEPTH_DEF;
    localparam logic [63:0] ID_MASK   = {64{1'b1}} >> (64 - 8 * mtjl_pkg::ID_BYTES_DEF);
    localparam int          N_ENDPTS  = 40;
    localparam int          N_IDS     = 24;
    localparam int          PHASE_LEN = 550;
    localparam int          HOLD_LEN  = 400;

    // software copy of the member table and the replies it predicts
    class join_leave_tracker;
        logic [mtjl_pkg::NODE_ID_W-1:0] node_id_tbl [DEPTH];
        logic [mtjl_pkg::ADDR_W-1:0]    addr_tbl [DEPTH];
        logic [mtjl_pkg::PORT_W-1:0]    port_tbl [DEPTH];
        logic                           super_tbl [DEPTH];
        logic                           removed_tbl [DEPTH];
        logic [mtjl_pkg::VER_W-1:0]     version_tbl [DEPTH];
        int                             entries_used;
        mtjl_pkg::rsp_t                 pending_replies[$];
        int unsigned                    bad_replies;

        function new();
            int i;
            for (i = 0; i < DEPTH; i++) begin
                node_id_tbl[i] = '0;
                addr_tbl[i]    = '0;
                port_tbl[i]    = '0;
                super_tbl[i]   = 1'b0;
                removed_tbl[i] = 1'b0;
                version_tbl[i] = '0;
            end
            entries_used = 0;
            bad_replies  = 0;
        endfunction

        function mtjl_pkg::rsp_t table_reply(mtjl_pkg::req_t r);
            mtjl_pkg::rsp_t                 rsp;
            logic [mtjl_pkg::NODE_ID_W-1:0] id;
            logic [mtjl_pkg::NODE_ID_W-1:0] src;
            int                             i;
            int                             hit;
            rsp = '0;
            id  = r.member_id & ID_MASK;
            src = r.source_id & ID_MASK;
            hit = -1;
            if (r.operation == mtjl_pkg::OP_LEAVE) begin
                for (i = 0; i < entries_used; i++) begin
                    if (hit < 0 && node_id_tbl[i] == id) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    removed_tbl[hit] = 1'b1;
                    rsp.entry_slot   = hit[mtjl_pkg::SLOT_W-1:0];
                end
                rsp.accepted   = 1'b1;
                rsp.error_code = mtjl_pkg::ERR_NONE;
                rsp.ack_id     = id;
            end else if (!r.header_is_join) begin
                rsp.error_code = mtjl_pkg::ERR_UNSUPPORTED;
            end else if (id != src || id == '0) begin
                rsp.error_code = mtjl_pkg::ERR_MALFORMED;
            end else if (r.member_kind > 2'd1) begin
                rsp.error_code = mtjl_pkg::ERR_BAD_KIND;
            end else if (r.member_address == '0 || r.member_port == '0) begin
                rsp.error_code = mtjl_pkg::ERR_MALFORMED;
            end else begin
                for (i = 0; i < entries_used; i++) begin
                    if (hit < 0 && addr_tbl[i] == r.member_address
                            && port_tbl[i] == r.member_port) begin
                        hit = i;
                    end
                end
                if (hit < 0 && entries_used >= DEPTH) begin
                    rsp.error_code = mtjl_pkg::ERR_FULL;
                end else begin
                    if (hit < 0) begin
                        hit = entries_used;
                        entries_used++;
                        version_tbl[hit] = '0;
                    end else begin
                        version_tbl[hit] = version_tbl[hit] + 1'b1;
                    end
                    node_id_tbl[hit]     = id;
                    addr_tbl[hit]        = r.member_address;
                    port_tbl[hit]        = r.member_port;
                    super_tbl[hit]       = r.member_kind[0];
                    removed_tbl[hit]     = 1'b0;
                    rsp.accepted         = 1'b1;
                    rsp.error_code       = mtjl_pkg::ERR_NONE;
                    rsp.ack_id           = id;
                    rsp.assigned_version = version_tbl[hit];
                    rsp.entry_slot       = hit[mtjl_pkg::SLOT_W-1:0];
                end
            end
            return rsp;
        endfunction

        function void note_request(mtjl_pkg::req_t r);
            pending_replies.push_back(table_reply(r));
        endfunction

        function void check_reply(mtjl_pkg::rsp_t got);
            mtjl_pkg::rsp_t want;
            if (pending_replies.size() == 0) begin
                bad_replies++;
                if (bad_replies <= 10) begin
                    $display("unexpected reply acc=%0d err=%0d id=%h ver=%0d slot=%0d",
                             got.accepted, got.error_code, got.ack_id,
                             got.assigned_version, got.entry_slot);
                end
                return;
            end
            want = pending_replies.pop_front();
            if (got.accepted !== want.accepted || got.error_code !== want.error_code
                    || got.ack_id !== want.ack_id
                    || got.assigned_version !== want.assigned_version
                    || got.entry_slot !== want.entry_slot) begin
                bad_replies++;
                if (bad_replies <= 10) begin
                    $display("reply mismatch at %0t: expected acc=%0d err=%0d id=%h ver=%0d slot=%0d",
                             $realtime, want.accepted, want.error_code, want.ack_id,
                             want.assigned_version, want.entry_slot);
                    $display("                      got acc=%0d err=%0d id=%h ver=%0d slot=%0d",
                             got.accepted, got.error_code, got.ack_id,
                             got.assigned_version, got.entry_slot);
                end
            end
        endfunction
    endclass

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    mtjl_pkg::req_t s_data;
    logic           m_valid;
    logic           m_ready;
    mtjl_pkg::rsp_t m_data;

    join_leave_tracker tracker = new();

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_requests;

    logic [mtjl_pkg::ADDR_W-1:0]    endpt_addr [N_ENDPTS];
    logic [mtjl_pkg::PORT_W-1:0]    endpt_port [N_ENDPTS];
    logic [mtjl_pkg::NODE_ID_W-1:0] id_pool [N_IDS];

    membership_table_join_leave_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic mtjl_pkg::req_t make_req(logic op, logic hdr, logic [63:0] src,
                                                logic [63:0] id, logic [1:0] kind,
                                                logic [31:0] addr, logic [15:0] port);
        mtjl_pkg::req_t r;
        r.operation      = op;
        r.header_is_join = hdr;
        r.source_id      = src;
        r.member_id      = id;
        r.member_kind    = kind;
        r.member_address = addr;
        r.member_port    = port;
        return r;
    endfunction

    // mostly well-formed joins and leaves over the pools, the rest malformed
    function automatic mtjl_pkg::req_t random_request();
        mtjl_pkg::req_t r;
        int unsigned    pick;
        int unsigned    e;
        logic [63:0]    id;
        pick = $urandom_range(99);
        e    = $urandom_range(N_ENDPTS - 1);
        id   = id_pool[$urandom_range(N_IDS - 1)];
        r    = make_req(mtjl_pkg::OP_JOIN, 1'b1, id, id, 2'($urandom_range(1)),
                        endpt_addr[e], endpt_port[e]);
        if (pick < 55) begin
            return r;
        end
        if (pick < 78) begin
            r = make_req(mtjl_pkg::OP_LEAVE, 1'($urandom_range(1)), rand64(), id,
                         2'($urandom_range(3)), $urandom, 16'($urandom_range(65535)));
            if ($urandom_range(9) == 0) begin
                r.member_id = $urandom_range(1) ? rand64() : '0;
            end
            return r;
        end
        case ($urandom_range(6))
            0: r.header_is_join = 1'b0;
            1: r.source_id = rand64();
            2: begin
                r.source_id = '0;
                r.member_id = '0;
            end
            3: r.member_kind = 2'($urandom_range(2, 3));
            4: r.member_address = '0;
            5: r.member_port = '0;
            default: begin
                r = make_req(mtjl_pkg::OP_JOIN, 1'($urandom_range(1)), rand64(), rand64(),
                             2'($urandom_range(3)), $urandom,
                             16'($urandom_range(65535)));
                if ($urandom_range(1)) begin
                    r.source_id = r.member_id;
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_req(input mtjl_pkg::req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        tracker.note_request(r);
    endtask

    // result side: checks transfers and owns m_ready, including the hold-off
    initial begin
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                tracker.check_reply(m_data);
            end
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        logic [63:0] id_a;
        logic [63:0] id_c;
        logic [63:0] id_d;
        int          i;
        int          ph;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        send_idle_pct = 30;
        recv_idle_pct = 55;
        hold_requests = 0;
        id_a          = {64{1'b1}};
        id_c          = 64'h8000_0000_0000_0001;
        id_d          = 64'h5555_5555_5555_5555;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // leave on an empty table
        send_req(make_req(mtjl_pkg::OP_LEAVE, 1'b1, '0, id_a, 2'd0, '0, '0));
        // join checks in priority order, most with the later faults present
        send_req(make_req(mtjl_pkg::OP_JOIN, 1'b0, 64'd5, 64'd6, 2'd3, '0, '0));
        send_req(make_req(mtjl_pkg::OP_JOIN, 1'b1, 64'd5, 64'd6, 2'd3, '0, '0));
        send_req(make_req(mtjl_pkg::OP_JOIN, 1'b1, '0, '0, 2'd0, 32'h0a00_0001, 16'd80));
        send_req(make_req(mtjl_pkg::OP_JOIN, 1'b1, 64'd7, 64'd7, 2'd2, '0, '0));
        send_req(make_req(mtjl_pkg::OP_JOIN, 1'b1, 64'd7, 64'd7, 2'd3, 32'h0a00_0001,
                          16'd80));
        send_req(make_req(mtjl_pkg::OP_JOIN, 1'b1, 64'd7, 64'd7, 2'd0, '0, 16'd80));
        send_req(make_req(mtjl_pkg::OP_JOIN, 1'b1, 64'd7, 64'd7, 2'd1, 32'h0a00_0001, '0));
        // appends, then an overwrite with a new id
        send_req(make_req(mtjl_pkg::OP_JOIN, 1'b1, id_a, id_a, 2'd1, {32{1'b1}},
                          {16{1'b1}}));
        send_req(make_req(mtjl_pkg::OP_JOIN, 1'b1, 64'd1, 64'd1, 2'd0, 32'd1, 16'd1));
        send_req(make_req(mtjl_pkg::OP_JOIN, 1'b1, id_c, id_c, 2'd0, {32{1'b1}},
                          {16{1'b1}}));
        // leaves: hit, repeat on a removed entry, ignored header, stale id, zero id
        send_req(make_req(mtjl_pkg::OP_LEAVE, 1'b1, '0, id_c, 2'd0, '0, '0));
        send_req(make_req(mtjl_pkg::OP_LEAVE, 1'b1, '0, id_c, 2'd0, '0, '0));
        send_req(make_req(mtjl_pkg::OP_LEAVE, 1'b0, rand64(), 64'd1, 2'd3, $urandom,
                          16'hffff));
        send_req(make_req(mtjl_pkg::OP_LEAVE, 1'b1, '0, id_a, 2'd0, '0, '0));
        send_req(make_req(mtjl_pkg::OP_LEAVE, 1'b1, '0, '0, 2'd0, '0, '0));
        // revive removed entries, then append one more
        send_req(make_req(mtjl_pkg::OP_JOIN, 1'b1, id_c, id_c, 2'd1, {32{1'b1}},
                          {16{1'b1}}));
        send_req(make_req(mtjl_pkg::OP_JOIN, 1'b1, 64'd1, 64'd1, 2'd1, 32'd1, 16'd1));
        send_req(make_req(mtjl_pkg::OP_JOIN, 1'b1, id_d, id_d, 2'd0, 32'h8000_0000,
                          16'h8000));

        // pools small enough that the table fills and then reports full
        for (i = 0; i < N_ENDPTS; i++) begin
            endpt_addr[i] = $urandom_range(32'hffff_ffff, 1);
            endpt_port[i] = 16'($urandom_range(65535, 1));
        end
        for (i = 0; i < N_IDS; i++) begin
            id_pool[i] = rand64();
        end

        for (ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 55;
                recv_idle_pct = 30;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_requests = hold_requests + 1;
            end
            for (i = 0; i < PHASE_LEN; i++) begin
                send_req(random_request());
            end
        end
        s_valid <= 1'b0;

        while (tracker.pending_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DEPTH + 8) @(posedge aclk);
        if (tracker.bad_replies == 0 && tracker.pending_replies.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
